>>> src/ffha_pkg.sv
package ffha_pkg;

    localparam int CFG_W    = 11;
    localparam int MODE_W   = 2;
    localparam int REQ_W    = 13;
    localparam int OFF_W    = 12;
    localparam int STAT_W   = 2;
    localparam int NEED_W   = 12;
    localparam int SIZE_W   = 17;
    localparam int CALC_W   = 19;

    localparam logic [1:0] MARK_FREE = 2'd1;
    localparam logic [1:0] MARK_USED = 2'd2;

    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FAIL = 2'd1;
    localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0]        mark;
        logic [SIZE_W-1:0] size;
    } hdr_t;

endpackage

>>> src/first_fit_heap_allocator.sv
// first-fit allocator over an in-band header store, one request word at a time
// allocate walks the block chain from the start; free marks the block free, then walks the
// chain to merge free neighbours (merge walk); clear rewrites the store; zero size or unknown
// mode fails without a walk; a rejected free returns bad status; each walk step waits on one header read
// reset and every cfg write start a clearing pass over the configured store size (1024 words
// at reset by default) with s_ready low; cfg_ready is high only while the block is idle
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int HEAP_WORDS   = 1024,
    parameter int HEADER_WORDS = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [MODE_W-1:0] s_mode,
    input  logic [REQ_W-1:0]  s_request_bytes,
    input  logic [OFF_W-1:0]  s_release_offset,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [OFF_W-1:0]  m_payload_offset
);

    localparam int AW     = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
    localparam int HW_W   = $clog2(HEAP_WORDS + 1);
    localparam int HW_MIN = HEADER_WORDS + 1;
    localparam int HW_RST = (1024 < HW_MIN) ? HW_MIN :
                            ((1024 > HEAP_WORDS) ? HEAP_WORDS : 1024);
    localparam logic [CALC_W-1:0] HDR_C  = CALC_W'(HEADER_WORDS);
    localparam logic [CALC_W-1:0] HDR1_C = CALC_W'(HEADER_WORDS + 1);

    localparam logic [3:0] ST_CLEAR   = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_A_RD    = 4'd2;
    localparam logic [3:0] ST_A_EVAL  = 4'd3;
    localparam logic [3:0] ST_A_MARK  = 4'd4;
    localparam logic [3:0] ST_F_CHK   = 4'd5;
    localparam logic [3:0] ST_F_EVAL  = 4'd6;
    localparam logic [3:0] ST_M_RD0   = 4'd7;
    localparam logic [3:0] ST_M_LOAD0 = 4'd8;
    localparam logic [3:0] ST_M_NEXT  = 4'd9;
    localparam logic [3:0] ST_M_EVAL  = 4'd10;
    localparam logic [3:0] ST_RESP    = 4'd11;

    logic [3:0]        state_reg, state_next;
    logic [HW_W-1:0]   hw_reg, hw_next;
    logic [HW_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic              clr_resp_reg, clr_resp_next;
    logic [NEED_W-1:0] need_reg, need_next;
    logic [OFF_W-1:0]  rel_reg, rel_next;
    logic [CALC_W-1:0] p_reg, p_next;
    logic [CALC_W-1:0] q_reg, q_next;
    hdr_t              hdr_reg, hdr_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [OFF_W-1:0]  off_reg, off_next;
    logic              m_valid_reg, m_valid_next;
    logic [STAT_W-1:0] m_status_reg, m_status_next;
    logic [OFF_W-1:0]  m_off_reg, m_off_next;

    logic          we;
    logic [AW-1:0] waddr;
    hdr_t          wdata;
    logic          re;
    logic [AW-1:0] raddr;
    hdr_t          rd_hdr;

    logic [CALC_W-1:0] hw_c, cfg_c, ph_c, rd_end_c, q_c, q_end_c, left_c, rel_w_c;
    logic [REQ_W:0]    req_rnd;
    logic [NEED_W-1:0] need_c;
    logic [HW_W-1:0]   cfg_sat;

    ffha_store #(
        .DEPTH (HEAP_WORDS),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rd_hdr)
    );

    assign hw_c     = CALC_W'(hw_reg);
    assign cfg_c    = CALC_W'(cfg_data);
    assign ph_c     = p_reg + HDR_C;
    assign rd_end_c = ph_c + CALC_W'(rd_hdr.size);
    assign q_c      = ph_c + CALC_W'(hdr_reg.size);
    assign q_end_c  = q_reg + HDR_C + CALC_W'(rd_hdr.size);
    assign left_c   = CALC_W'(rd_hdr.size) - CALC_W'(need_reg);
    assign rel_w_c  = CALC_W'(rel_reg[OFF_W-1:2]);
    assign req_rnd  = (REQ_W+1)'(s_request_bytes) + (REQ_W+1)'(3);
    assign need_c   = NEED_W'(req_rnd >> 2);

    always_comb begin
        if (cfg_c < HDR1_C) begin
            cfg_sat = HW_W'(HW_MIN);
        end else if (cfg_c > CALC_W'(HEAP_WORDS)) begin
            cfg_sat = HW_W'(HEAP_WORDS);
        end else begin
            cfg_sat = HW_W'(cfg_c);
        end
    end

    assign cfg_ready        = (state_reg == ST_IDLE);
    assign s_ready          = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_payload_offset = m_off_reg;

    always_comb begin
        state_next    = state_reg;
        hw_next       = hw_reg;
        clr_cnt_next  = clr_cnt_reg;
        clr_resp_next = clr_resp_reg;
        need_next     = need_reg;
        rel_next      = rel_reg;
        p_next        = p_reg;
        q_next        = q_reg;
        hdr_next      = hdr_reg;
        st_next       = st_reg;
        off_next      = off_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_status_next = m_status_reg;
        m_off_next    = m_off_reg;
        we            = 1'b0;
        waddr         = p_reg[AW-1:0];
        wdata         = '0;
        re            = 1'b0;
        raddr         = p_reg[AW-1:0];

        case (state_reg)
            ST_CLEAR: begin
                we    = 1'b1;
                waddr = clr_cnt_reg[AW-1:0];
                if (clr_cnt_reg == '0) begin
                    wdata.mark = MARK_FREE;
                    wdata.size = SIZE_W'(hw_c - HDR_C);
                end
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == hw_reg - 1'b1) begin
                    state_next = clr_resp_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (cfg_valid) begin
                    hw_next       = cfg_sat;
                    clr_cnt_next  = '0;
                    clr_resp_next = 1'b0;
                    state_next    = ST_CLEAR;
                end else if (s_valid) begin
                    off_next = '0;
                    p_next   = '0;
                    case (s_mode)
                        MODE_ALLOC: begin
                            need_next = need_c;
                            if (need_c == '0) begin
                                st_next    = STAT_FAIL;
                                state_next = ST_RESP;
                            end else begin
                                state_next = ST_A_RD;
                            end
                        end
                        MODE_FREE: begin
                            rel_next   = s_release_offset;
                            state_next = ST_F_CHK;
                        end
                        MODE_CLEAR: begin
                            clr_cnt_next  = '0;
                            clr_resp_next = 1'b1;
                            st_next       = STAT_OK;
                            state_next    = ST_CLEAR;
                        end
                        default: begin
                            st_next    = STAT_FAIL;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_A_RD: begin
                if (ph_c + 1'b1 > hw_c) begin
                    st_next    = STAT_FAIL;
                    state_next = ST_RESP;
                end else begin
                    re         = 1'b1;
                    state_next = ST_A_EVAL;
                end
            end
            ST_A_EVAL: begin
                if (rd_end_c > hw_c) begin
                    st_next    = STAT_FAIL;
                    state_next = ST_RESP;
                end else if (rd_hdr.mark == MARK_FREE &&
                             CALC_W'(rd_hdr.size) >= CALC_W'(need_reg)) begin
                    st_next  = STAT_OK;
                    off_next = {ph_c[OFF_W-3:0], 2'b00};
                    we       = 1'b1;
                    if (left_c >= HDR1_C) begin
                        waddr      = AW'(ph_c + CALC_W'(need_reg));
                        wdata.mark = MARK_FREE;
                        wdata.size = SIZE_W'(left_c - HDR_C);
                        state_next = ST_A_MARK;
                    end else begin
                        wdata.mark = MARK_USED;
                        wdata.size = rd_hdr.size;
                        state_next = ST_RESP;
                    end
                end else begin
                    p_next     = rd_end_c;
                    state_next = ST_A_RD;
                end
            end
            ST_A_MARK: begin
                we         = 1'b1;
                wdata.mark = MARK_USED;
                wdata.size = SIZE_W'(need_reg);
                state_next = ST_RESP;
            end
            ST_F_CHK: begin
                if (rel_reg[1:0] != 2'b00 || rel_w_c < HDR_C || rel_w_c >= hw_c) begin
                    st_next    = STAT_BAD;
                    state_next = ST_RESP;
                end else begin
                    p_next     = rel_w_c - HDR_C;
                    re         = 1'b1;
                    raddr      = AW'(rel_w_c - HDR_C);
                    st_next    = STAT_OK;
                    state_next = ST_F_EVAL;
                end
            end
            ST_F_EVAL: begin
                if (rd_hdr.mark != MARK_USED) begin
                    st_next    = STAT_BAD;
                    state_next = ST_RESP;
                end else begin
                    we         = 1'b1;
                    wdata.mark = MARK_FREE;
                    wdata.size = rd_hdr.size;
                    state_next = ST_M_RD0;
                end
            end
            ST_M_RD0: begin
                re         = 1'b1;
                raddr      = '0;
                state_next = ST_M_LOAD0;
            end
            ST_M_LOAD0: begin
                if (HDR_C + CALC_W'(rd_hdr.size) > hw_c) begin
                    state_next = ST_RESP;
                end else begin
                    hdr_next   = rd_hdr;
                    p_next     = '0;
                    state_next = ST_M_NEXT;
                end
            end
            ST_M_NEXT: begin
                if (q_c + HDR1_C > hw_c) begin
                    state_next = ST_RESP;
                end else begin
                    re         = 1'b1;
                    raddr      = q_c[AW-1:0];
                    q_next     = q_c;
                    state_next = ST_M_EVAL;
                end
            end
            ST_M_EVAL: begin
                if (q_end_c > hw_c) begin
                    state_next = ST_RESP;
                end else if (hdr_reg.mark == MARK_FREE && rd_hdr.mark == MARK_FREE) begin
                    we            = 1'b1;
                    wdata.mark    = MARK_FREE;
                    wdata.size    = SIZE_W'(CALC_W'(hdr_reg.size) + HDR_C +
                                            CALC_W'(rd_hdr.size));
                    hdr_next.size = wdata.size;
                    state_next    = ST_M_NEXT;
                end else begin
                    p_next     = q_reg;
                    hdr_next   = rd_hdr;
                    state_next = ST_M_NEXT;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = st_reg;
                    m_off_next    = off_reg;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            hw_reg       <= HW_W'(HW_RST);
            clr_cnt_reg  <= '0;
            clr_resp_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            hw_reg       <= hw_next;
            clr_cnt_reg  <= clr_cnt_next;
            clr_resp_reg <= clr_resp_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        need_reg     <= need_next;
        rel_reg      <= rel_next;
        p_reg        <= p_next;
        q_reg        <= q_next;
        hdr_reg      <= hdr_next;
        st_reg       <= st_next;
        off_reg      <= off_next;
        m_status_reg <= m_status_next;
        m_off_reg    <= m_off_next;
    end

    a_hw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hw_reg >= HW_W'(HW_MIN) && hw_reg <= HW_W'(HEAP_WORDS))
        else $error("store size out of range");

    a_clear_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> clr_cnt_reg < hw_reg)
        else $error("clearing pass past end of store");

    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_A_EVAL || state_reg == ST_F_EVAL) |-> p_reg < hw_c)
        else $error("header read past end of store");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != STAT_OK |-> m_off_reg == '0)
        else $error("nonzero offset on failed request");

    a_off_align: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_off_reg[1:0] == 2'b00)
        else $error("misaligned payload offset");

endmodule

>>> src/ffha_store.sv
module ffha_store
    import ffha_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  hdr_t          wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output hdr_t          rdata
);

    hdr_t mem [DEPTH];
    hdr_t rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
